// File: hw/rtl/fhld_pkg.sv
package fhld_pkg;

    localparam int CountBitsDefault = 16;
    localparam int BufW             = 16;
    localparam int FillW            = 5;
    localparam int ByteW            = 8;
    localparam int LenW             = 4;
    localparam int PaddrW           = 3;
    localparam int PdataW           = 32;
    localparam int RegCountW        = 16;

    localparam logic REG_LITERAL_COUNT = 1'b0;

    typedef enum logic [1:0] {
        DEC_NEED,
        DEC_LIT,
        DEC_ERR
    } t_dec_kind;

    typedef struct packed {
        t_dec_kind        kind;
        logic [ByteW-1:0] sym;
        logic [LenW-1:0]  len;
    } t_dec;

    typedef struct packed {
        logic [BufW-1:0]  bit_buffer;
        logic [FillW-1:0] buffered_bits;
    } t_bits;

    typedef struct packed {
        logic [ByteW-1:0] literal;
        logic             last_literal;
        logic             code_error;
    } t_result;

    function automatic t_dec decode_code(input logic [BufW-1:0] bb,
                                         input logic [FillW-1:0] nbits);
        logic [8:0] rev;
        logic [6:0] c7;
        logic [7:0] c8;
        t_dec       d;
        for (int i = 0; i < 9; i++) begin
            rev[8-i] = bb[i];
        end
        c7     = rev[8:2];
        c8     = rev[8:1];
        d.kind = DEC_NEED;
        d.sym  = '0;
        d.len  = '0;
        if (nbits >= FillW'(7)) begin
            if (c7 <= 7'd23) begin
                d.kind = DEC_ERR;
            end else if (nbits >= FillW'(8)) begin
                if (c8 >= 8'd48 && c8 <= 8'd191) begin
                    d.kind = DEC_LIT;
                    d.sym  = c8 - 8'd48;
                    d.len  = LenW'(8);
                end else if (c8 >= 8'd192 && c8 <= 8'd199) begin
                    d.kind = DEC_ERR;
                end else if (nbits >= FillW'(9)) begin
                    d.kind = DEC_LIT;
                    d.sym  = rev[7:0];
                    d.len  = LenW'(9);
                end
            end
        end
        return d;
    endfunction

endpackage

// File: hw/rtl/fhld_step.sv
module fhld_step #(
    parameter int COUNT_BITS = fhld_pkg::CountBitsDefault
) (
    input  fhld_pkg::t_bits                i_bits,
    input  logic                           i_halted,
    input  logic [COUNT_BITS-1:0]          i_done,
    input  logic [COUNT_BITS-1:0]          i_count,
    input  logic [fhld_pkg::ByteW-1:0]     i_byte,
    output fhld_pkg::t_bits                o_bits,
    output logic                           o_halted,
    output logic [COUNT_BITS-1:0]          o_done,
    output logic [1:0]                     o_push_n,
    output fhld_pkg::t_result              o_res0,
    output fhld_pkg::t_result              o_res1
);
    import fhld_pkg::*;

    logic [BufW-1:0]       b0;
    logic [BufW-1:0]       b1;
    logic [BufW-1:0]       b2;
    logic [FillW-1:0]      n0;
    logic [FillW-1:0]      n1;
    logic [FillW-1:0]      n2;
    logic [COUNT_BITS-1:0] done1;
    logic [COUNT_BITS-1:0] done2;
    t_dec                  d1;
    t_dec                  d2;
    logic                  take1;
    logic                  err1;
    logic                  take2;
    logic                  err2;

    always_comb begin
        if (i_bits.buffered_bits <= FillW'(8)) begin
            b0 = i_bits.bit_buffer | (BufW'(i_byte) << i_bits.buffered_bits[3:0]);
            n0 = i_bits.buffered_bits + FillW'(8);
        end else begin
            b0 = i_bits.bit_buffer;
            n0 = i_bits.buffered_bits;
        end
    end

    assign d1    = decode_code(b0, n0);
    assign take1 = !i_halted && (i_done < i_count) && (d1.kind == DEC_LIT);
    assign err1  = !i_halted && (i_done < i_count) && (d1.kind == DEC_ERR);
    assign b1    = b0 >> d1.len;
    assign n1    = n0 - FillW'(d1.len);
    assign done1 = i_done + COUNT_BITS'(1);

    assign d2    = decode_code(b1, n1);
    assign take2 = take1 && (done1 < i_count) && (d2.kind == DEC_LIT);
    assign err2  = take1 && (done1 < i_count) && (d2.kind == DEC_ERR);
    assign b2    = b1 >> d2.len;
    assign n2    = n1 - FillW'(d2.len);
    assign done2 = done1 + COUNT_BITS'(1);

    always_comb begin
        o_bits   = i_bits;
        o_done   = i_done;
        o_halted = i_halted || err1 || err2;
        if (!i_halted) begin
            if (take2) begin
                o_bits.bit_buffer    = b2;
                o_bits.buffered_bits = n2;
                o_done               = done2;
            end else if (take1) begin
                o_bits.bit_buffer    = b1;
                o_bits.buffered_bits = n1;
                o_done               = done1;
            end else begin
                o_bits.bit_buffer    = b0;
                o_bits.buffered_bits = n0;
            end
        end
    end

    always_comb begin
        o_res0 = '0;
        o_res1 = '0;
        if (err1) begin
            o_res0.code_error = 1'b1;
        end else begin
            o_res0.literal      = d1.sym;
            o_res0.last_literal = (done1 == i_count);
        end
        if (err2) begin
            o_res1.code_error = 1'b1;
        end else begin
            o_res1.literal      = d2.sym;
            o_res1.last_literal = (done2 == i_count);
        end
        if (take1 && (take2 || err2)) begin
            o_push_n = 2'd2;
        end else if (take1 || err1) begin
            o_push_n = 2'd1;
        end else begin
            o_push_n = 2'd0;
        end
    end

endmodule

// File: hw/rtl/fhld_result_fifo.sv
module fhld_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_n,
    input  fhld_pkg::t_result  i_res0,
    input  fhld_pkg::t_result  i_res1,
    input  logic               i_pop_ready,
    output logic               o_valid,
    output fhld_pkg::t_result  o_res,
    output logic               o_space
);
    import fhld_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wptr;
    logic [1:0] r_rptr;
    logic [2:0] r_count;
    logic [1:0] n_wptr;
    logic [1:0] n_rptr;
    logic [2:0] n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rptr];
    assign o_space = (r_count <= 3'd2);
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_wptr  = r_wptr + i_push_n;
        n_rptr  = r_rptr + 2'(pop);
        n_count = r_count + 3'(i_push_n) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wptr + 2'd1] <= i_res1;
        end
    end

endmodule

// File: hw/rtl/fixed_huffman_literal_decoder_core.sv
// Channel   Direction  Handshake                       Payload
// stream    in         i_stream_valid / o_stream_ready i_stream_byte
// result    out        o_result_valid / i_result_ready o_literal, o_last_literal, o_code_error
// config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A byte is decoded in the cycle it transfers; up to two results enter a four-entry queue.
// o_stream_ready is high while at most two results are queued, so a byte can transfer every
// cycle; the result port drains one per cycle while i_result_ready is high.
// Reset is synchronous; no clearing pass.
// A stalled result port fills the queue and holds o_stream_ready low until it drains.
module fixed_huffman_literal_decoder_core #(
    parameter int COUNT_BITS = fhld_pkg::CountBitsDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_stream_valid,
    output logic                            o_stream_ready,
    input  logic [fhld_pkg::ByteW-1:0]      i_stream_byte,
    output logic                            o_result_valid,
    input  logic                            i_result_ready,
    output logic [fhld_pkg::ByteW-1:0]      o_literal,
    output logic                            o_last_literal,
    output logic                            o_code_error,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fhld_pkg::PaddrW-1:0]     paddr,
    input  logic [fhld_pkg::PdataW-1:0]     pwdata,
    output logic [fhld_pkg::PdataW-1:0]     prdata,
    output logic                            pready
);
    import fhld_pkg::*;

    localparam int LoadW = (COUNT_BITS < RegCountW) ? COUNT_BITS : RegCountW;

    t_bits                 r_bits;
    logic                  r_halted;
    logic [COUNT_BITS-1:0] r_done;
    logic [COUNT_BITS-1:0] r_literal_count;
    t_bits                 n_bits;
    logic                  n_halted;
    logic [COUNT_BITS-1:0] n_done;
    logic [1:0]            step_push_n;
    logic [1:0]            push_n;
    t_result               res0;
    t_result               res1;
    t_result               out_res;
    logic                  in_xfer;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign in_xfer = i_stream_valid && o_stream_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == REG_LITERAL_COUNT) ? PdataW'(r_literal_count) : '0;

    fhld_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .i_bits  (r_bits),
        .i_halted(r_halted),
        .i_done  (r_done),
        .i_count (r_literal_count),
        .i_byte  (i_stream_byte),
        .o_bits  (n_bits),
        .o_halted(n_halted),
        .o_done  (n_done),
        .o_push_n(step_push_n),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    assign push_n = in_xfer ? step_push_n : 2'd0;

    fhld_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop_ready(i_result_ready),
        .o_valid    (o_result_valid),
        .o_res      (out_res),
        .o_space    (o_stream_ready)
    );

    assign o_literal      = out_res.literal;
    assign o_last_literal = out_res.last_literal;
    assign o_code_error   = out_res.code_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits   <= '0;
            r_halted <= 1'b0;
            r_done   <= '0;
        end else if (in_xfer) begin
            r_bits   <= n_bits;
            r_halted <= n_halted;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_literal_count <= '0;
        end else if (cfg_wr && paddr[2] == REG_LITERAL_COUNT) begin
            r_literal_count <= COUNT_BITS'(pwdata[LoadW-1:0]);
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits.buffered_bits <= FillW'(16))
        else $error("bit buffer fill out of range");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_halted) |-> (push_n == 2'd0))
        else $error("result pushed while halted");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0 && (res0.code_error || (push_n == 2'd2 && res1.code_error)))
        |=> r_halted)
        else $error("code error did not halt decoding");

    a_error_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n == 2'd2) |-> !res0.code_error)
        else $error("result follows a code error");

endmodule
